/* rtl/core/tno_pkg.sv */
package tno_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits = 16;
   localparam int EdgeLimit = 30;
   localparam int NormLimit = 31;
   localparam int EdgeWidth = CoordWidth + 1;
   localparam int EdgeShiftWidth = $clog2(EdgeWidth - EdgeLimit + 1);
   localparam int ProdWidth = 2 * EdgeLimit;
   localparam int CrossWidth = ProdWidth + 1;
   localparam int NormShiftWidth = $clog2(CrossWidth - NormLimit + 1);
   localparam int SquareWidth = 2 * NormLimit;
   localparam int SumWidth = SquareWidth + 2;
   localparam int RootWidth = SumWidth / 2;
   localparam int RemWidth = RootWidth + 3;
   localparam int NumWidth = NormLimit + FracBits + 1;
   localparam int QuotWidth = FracBits + 1;
   localparam int DivRemWidth = RootWidth + 1;
   localparam int PartWidth = CoordWidth - FracBits + QuotWidth;
   localparam int LowWidth = FracBits + QuotWidth;
   localparam int DeltaWidth = CoordWidth + 2;
   localparam int MoveWidth = CoordWidth + 3;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [8:0][CoordWidth-1:0] vert_type;

   typedef struct packed {
      vert_type vert;
      logic [2:0][NormLimit-1:0] nmag;
      logic [2:0] nneg;
      logic [SumWidth-1:0] sum;
      logic degen;
   } front_type;

   typedef struct packed {
      vert_type vert;
      logic [2:0][NormLimit-1:0] nmag;
      logic [2:0] nneg;
      logic [RootWidth-1:0] root;
      logic degen;
   } root_type;

   typedef struct packed {
      vert_type vert;
      logic [2:0][QuotWidth-1:0] umag;
      logic [2:0] nneg;
      logic degen;
   } unit_type;

   typedef struct packed {
      vert_type vert;
      logic degen;
   } result_type;

endpackage

/* rtl/core/tno_if.sv */
interface tno_req_if;
   logic valid;
   logic ready;
   tno_pkg::coord_type ax, ay, az, bx, by, bz, cx, cy, cz;
   modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
   modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tno_rsp_if;
   logic valid;
   logic ready;
   tno_pkg::coord_type new_ax, new_ay, new_az, new_bx, new_by, new_bz;
   tno_pkg::coord_type new_cx, new_cy, new_cz;
   logic degenerate;
   modport source (output valid, new_ax, new_ay, new_az, new_bx, new_by, new_bz,
                   new_cx, new_cy, new_cz, degenerate, input ready);
   modport sink (input valid, new_ax, new_ay, new_az, new_bx, new_by, new_bz,
                 new_cx, new_cy, new_cz, degenerate, output ready);
endinterface

interface tno_csr_if;
   logic valid;
   logic ready;
   tno_pkg::coord_type offset_length;
   modport source (output valid, offset_length, input ready);
   modport sink (input valid, offset_length, output ready);
endinterface

/* rtl/core/tno_front.sv */
module tno_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tno_pkg::vert_type   in_vert,
   output logic                out_valid,
   output tno_pkg::front_type  out_data
);

   logic [7:1] v_ff;
   tno_pkg::vert_type vert_ff [1:6];

   logic [5:0][tno_pkg::EdgeWidth-1:0] emag_in, emag_ff;
   logic [5:0] eneg_in, eneg_ff;
   logic [5:0][tno_pkg::EdgeLimit-1:0] sm_in, sm_ff;
   logic [5:0] sneg_ff;
   logic [5:0][tno_pkg::ProdWidth-1:0] pmag_in, pmag_ff;
   logic [5:0] pneg_in, pneg_ff;
   logic [2:0][tno_pkg::CrossWidth-1:0] nmag_in, nmag_ff;
   logic [2:0] nneg_in, nneg_ff, nneg5_ff, nneg6_ff;
   logic [2:0][tno_pkg::NormLimit-1:0] nm_in, nm_ff, nm6_ff;
   logic [2:0][tno_pkg::SquareWidth-1:0] sq_ff;
   logic [tno_pkg::EdgeWidth-1:0] eor;
   logic [tno_pkg::EdgeShiftWidth-1:0] esh;
   logic [tno_pkg::CrossWidth-1:0] nor_all;
   logic [tno_pkg::NormShiftWidth-1:0] nsh;
   logic [tno_pkg::SumWidth-1:0] sum_in;
   logic [tno_pkg::EdgeWidth-1:0] ed;
   logic [tno_pkg::CrossWidth:0] pa, pb, nd;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ed = {in_vert[3+i][tno_pkg::CoordWidth-1], in_vert[3+i]}
            - {in_vert[i][tno_pkg::CoordWidth-1], in_vert[i]};
         eneg_in[i] = ed[tno_pkg::EdgeWidth-1];
         emag_in[i] = ed[tno_pkg::EdgeWidth-1] ? (~ed + 1'b1) : ed;
         ed = {in_vert[6+i][tno_pkg::CoordWidth-1], in_vert[6+i]}
            - {in_vert[3+i][tno_pkg::CoordWidth-1], in_vert[3+i]};
         eneg_in[3+i] = ed[tno_pkg::EdgeWidth-1];
         emag_in[3+i] = ed[tno_pkg::EdgeWidth-1] ? (~ed + 1'b1) : ed;
      end
   end

   always_comb begin
      eor = '0;
      for (int j = 0; j < 6; j++) eor = eor | emag_ff[j];
      esh = '0;
      for (int b = tno_pkg::EdgeLimit; b < tno_pkg::EdgeWidth; b++) begin
         if (eor[b]) esh = tno_pkg::EdgeShiftWidth'(b - tno_pkg::EdgeLimit + 1);
      end
      for (int j = 0; j < 6; j++) sm_in[j] = tno_pkg::EdgeLimit'(emag_ff[j] >> esh);
   end

   always_comb begin
      pmag_in[0] = sm_ff[1] * sm_ff[5];
      pmag_in[1] = sm_ff[2] * sm_ff[4];
      pmag_in[2] = sm_ff[2] * sm_ff[3];
      pmag_in[3] = sm_ff[0] * sm_ff[5];
      pmag_in[4] = sm_ff[0] * sm_ff[4];
      pmag_in[5] = sm_ff[1] * sm_ff[3];
      pneg_in[0] = sneg_ff[1] ^ sneg_ff[5];
      pneg_in[1] = sneg_ff[2] ^ sneg_ff[4];
      pneg_in[2] = sneg_ff[2] ^ sneg_ff[3];
      pneg_in[3] = sneg_ff[0] ^ sneg_ff[5];
      pneg_in[4] = sneg_ff[0] ^ sneg_ff[4];
      pneg_in[5] = sneg_ff[1] ^ sneg_ff[3];
   end

   always_comb begin
      pa = '0;
      pb = '0;
      nd = '0;
      for (int i = 0; i < 3; i++) begin
         pa = {2'b00, pmag_ff[2*i]};
         if (pneg_ff[2*i]) pa = ~pa + 1'b1;
         pb = {2'b00, pmag_ff[2*i+1]};
         if (pneg_ff[2*i+1]) pb = ~pb + 1'b1;
         nd = pa - pb;
         nneg_in[i] = nd[tno_pkg::CrossWidth];
         if (nd[tno_pkg::CrossWidth]) nd = ~nd + 1'b1;
         nmag_in[i] = nd[tno_pkg::CrossWidth-1:0];
      end
   end

   always_comb begin
      nor_all = nmag_ff[0] | nmag_ff[1] | nmag_ff[2];
      nsh = '0;
      for (int b = tno_pkg::NormLimit; b < tno_pkg::CrossWidth; b++) begin
         if (nor_all[b]) nsh = tno_pkg::NormShiftWidth'(b - tno_pkg::NormLimit + 1);
      end
      for (int i = 0; i < 3; i++) nm_in[i] = tno_pkg::NormLimit'(nmag_ff[i] >> nsh);
   end

   assign sum_in = tno_pkg::SumWidth'(sq_ff[0]) + tno_pkg::SumWidth'(sq_ff[1])
                 + tno_pkg::SumWidth'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[6:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vert_ff[1] <= in_vert;
         for (int k = 2; k <= 6; k++) vert_ff[k] <= vert_ff[k-1];
         emag_ff <= emag_in;
         eneg_ff <= eneg_in;
         sm_ff <= sm_in;
         sneg_ff <= eneg_ff;
         pmag_ff <= pmag_in;
         pneg_ff <= pneg_in;
         nmag_ff <= nmag_in;
         nneg_ff <= nneg_in;
         nm_ff <= nm_in;
         nneg5_ff <= nneg_ff;
         for (int i = 0; i < 3; i++) sq_ff[i] <= nm_ff[i] * nm_ff[i];
         nm6_ff <= nm_ff;
         nneg6_ff <= nneg5_ff;
         out_data.vert <= vert_ff[6];
         out_data.nmag <= nm6_ff;
         out_data.nneg <= nneg6_ff;
         out_data.sum <= sum_in;
         out_data.degen <= (sum_in == '0);
      end
   end

   assign out_valid = v_ff[7];

endmodule

/* rtl/core/tno_sqrt.sv */
module tno_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tno_pkg::front_type  in_data,
   output logic                out_valid,
   output tno_pkg::root_type   out_data
);

   localparam int Steps = tno_pkg::RootWidth;

   logic [Steps-1:0] v_ff;
   tno_pkg::front_type car_ff [Steps];
   logic [tno_pkg::RemWidth-1:0] rem_ff [Steps];
   logic [tno_pkg::RemWidth-1:0] rem_in [Steps];
   logic [tno_pkg::RootWidth-1:0] root_ff [Steps];
   logic [tno_pkg::RootWidth-1:0] root_in [Steps];
   logic [tno_pkg::RemWidth-1:0] rem_p, rem_t;
   logic [tno_pkg::RootWidth-1:0] root_p;
   logic [tno_pkg::RootWidth+1:0] trial;
   tno_pkg::front_type car_p;

   always_comb begin
      rem_p = '0;
      root_p = '0;
      rem_t = '0;
      trial = '0;
      car_p = in_data;
      for (int k = 0; k < Steps; k++) begin
         if (k == 0) begin
            rem_p = '0;
            root_p = '0;
            car_p = in_data;
         end else begin
            rem_p = rem_ff[k-1];
            root_p = root_ff[k-1];
            car_p = car_ff[k-1];
         end
         rem_t = {rem_p[tno_pkg::RemWidth-3:0], car_p.sum[tno_pkg::SumWidth-1-2*k -: 2]};
         trial = {root_p, 2'b01};
         if (rem_t >= {1'b0, trial}) begin
            rem_in[k] = rem_t - {1'b0, trial};
            root_in[k] = {root_p[tno_pkg::RootWidth-2:0], 1'b1};
         end else begin
            rem_in[k] = rem_t;
            root_in[k] = {root_p[tno_pkg::RootWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[Steps-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         car_ff[0] <= in_data;
         for (int k = 1; k < Steps; k++) car_ff[k] <= car_ff[k-1];
         for (int k = 0; k < Steps; k++) begin
            rem_ff[k] <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = v_ff[Steps-1];
   assign out_data.vert = car_ff[Steps-1].vert;
   assign out_data.nmag = car_ff[Steps-1].nmag;
   assign out_data.nneg = car_ff[Steps-1].nneg;
   assign out_data.root = root_ff[Steps-1];
   assign out_data.degen = car_ff[Steps-1].degen;

endmodule

/* rtl/core/tno_div.sv */
module tno_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tno_pkg::root_type  in_data,
   output logic               out_valid,
   output tno_pkg::unit_type  out_data
);

   localparam int Steps = tno_pkg::QuotWidth;

   logic pre_v_ff;
   tno_pkg::root_type pre_ff;
   logic [2:0][tno_pkg::NumWidth-1:0] num_ff;
   logic [Steps-1:0] v_ff;
   tno_pkg::root_type car_ff [Steps];
   logic [2:0][tno_pkg::NumWidth-1:0] cnum_ff [Steps];
   logic [2:0][tno_pkg::DivRemWidth-1:0] rem_ff [Steps];
   logic [2:0][tno_pkg::DivRemWidth-1:0] rem_in [Steps];
   logic [2:0][tno_pkg::QuotWidth-1:0] quo_ff [Steps];
   logic [2:0][tno_pkg::QuotWidth-1:0] quo_in [Steps];
   logic [2:0][tno_pkg::DivRemWidth-1:0] rem_p;
   logic [2:0][tno_pkg::QuotWidth-1:0] quo_p;
   logic [2:0][tno_pkg::NumWidth-1:0] num_p;
   logic [tno_pkg::RootWidth-1:0] len_p;
   logic [tno_pkg::DivRemWidth-1:0] rem_t;

   always_comb begin
      rem_p = '0;
      quo_p = '0;
      num_p = '0;
      len_p = '0;
      rem_t = '0;
      for (int k = 0; k < Steps; k++) begin
         if (k == 0) begin
            num_p = num_ff;
            len_p = pre_ff.root;
            quo_p = '0;
            for (int i = 0; i < 3; i++) begin
               rem_p[i] = tno_pkg::DivRemWidth'(num_ff[i][tno_pkg::NumWidth-1:Steps]);
            end
         end else begin
            num_p = cnum_ff[k-1];
            len_p = car_ff[k-1].root;
            quo_p = quo_ff[k-1];
            rem_p = rem_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            rem_t = {rem_p[i][tno_pkg::DivRemWidth-2:0], num_p[i][Steps-1-k]};
            if (rem_t >= {1'b0, len_p}) begin
               rem_in[k][i] = rem_t - {1'b0, len_p};
               quo_in[k][i] = {quo_p[i][Steps-2:0], 1'b1};
            end else begin
               rem_in[k][i] = rem_t;
               quo_in[k][i] = {quo_p[i][Steps-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= 1'b0;
         v_ff <= '0;
      end else if (en) begin
         pre_v_ff <= in_valid;
         v_ff <= {v_ff[Steps-2:0], pre_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff <= in_data;
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {1'b0, in_data.nmag[i], {tno_pkg::FracBits{1'b0}}}
                       + tno_pkg::NumWidth'(in_data.root >> 1);
         end
         car_ff[0] <= pre_ff;
         cnum_ff[0] <= num_ff;
         for (int k = 1; k < Steps; k++) begin
            car_ff[k] <= car_ff[k-1];
            cnum_ff[k] <= cnum_ff[k-1];
         end
         for (int k = 0; k < Steps; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid = v_ff[Steps-1];
   assign out_data.vert = car_ff[Steps-1].vert;
   assign out_data.umag = quo_ff[Steps-1];
   assign out_data.nneg = car_ff[Steps-1].nneg;
   assign out_data.degen = car_ff[Steps-1].degen;

endmodule

/* rtl/core/tno_move.sv */
module tno_move (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  tno_pkg::coord_type   offset,
   input  logic                 in_valid,
   input  tno_pkg::unit_type    in_data,
   output logic                 out_valid,
   output tno_pkg::result_type  out_data
);

   localparam int Cw = tno_pkg::CoordWidth;
   localparam int Fb = tno_pkg::FracBits;

   logic [2:0] v_ff;
   logic [Cw-1:0] om;
   logic [2:0][tno_pkg::PartWidth-1:0] ph_ff;
   logic [2:0][tno_pkg::LowWidth-1:0] pl_ff;
   logic [2:0] neg_ff;
   tno_pkg::vert_type vert1_ff, vert2_ff;
   logic degen1_ff, degen2_ff;
   logic [2:0][tno_pkg::DeltaWidth-1:0] d_in, d_ff;
   logic [tno_pkg::DeltaWidth-1:0] dm;
   logic [tno_pkg::MoveWidth-1:0] mv;
   tno_pkg::vert_type res_in;
   logic [tno_pkg::MoveWidth-1:0] hi_lim, lo_lim;

   assign om = offset[Cw-1] ? (~offset + 1'b1) : offset;
   assign hi_lim = tno_pkg::MoveWidth'({1'b0, {(Cw-1){1'b1}}});
   assign lo_lim = ~hi_lim;

   always_comb begin
      dm = '0;
      for (int i = 0; i < 3; i++) begin
         dm = tno_pkg::DeltaWidth'(ph_ff[i])
            + tno_pkg::DeltaWidth'((pl_ff[i] + tno_pkg::LowWidth'(1 << (Fb - 1))) >> Fb);
         d_in[i] = neg_ff[i] ? (~dm + 1'b1) : dm;
      end
   end

   always_comb begin
      mv = '0;
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            mv = {{(tno_pkg::MoveWidth-Cw){vert2_ff[3*k+i][Cw-1]}}, vert2_ff[3*k+i]}
               + {{(tno_pkg::MoveWidth-tno_pkg::DeltaWidth){d_ff[i][tno_pkg::DeltaWidth-1]}},
                  d_ff[i]};
            if ($signed(mv) > $signed(hi_lim)) begin
               res_in[3*k+i] = hi_lim[Cw-1:0];
            end else if ($signed(mv) < $signed(lo_lim)) begin
               res_in[3*k+i] = lo_lim[Cw-1:0];
            end else begin
               res_in[3*k+i] = mv[Cw-1:0];
            end
            if (degen2_ff) res_in[3*k+i] = vert2_ff[3*k+i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ph_ff[i] <= om[Cw-1:Fb] * in_data.umag[i];
            pl_ff[i] <= om[Fb-1:0] * in_data.umag[i];
            neg_ff[i] <= offset[Cw-1] ^ in_data.nneg[i];
         end
         vert1_ff <= in_data.vert;
         degen1_ff <= in_data.degen;
         d_ff <= d_in;
         vert2_ff <= vert1_ff;
         degen2_ff <= degen1_ff;
         out_data.vert <= res_in;
         out_data.degen <= degen2_ff;
      end
   end

   assign out_valid = v_ff[2];

endmodule

/* rtl/core/triangle_normal_offset.sv */
// Moves each triangle along its unit normal by a programmable distance.
// The req_ch channel takes one triangle per item: vertices A, B and C as
// signed Q16.16 coordinates. The rsp_ch channel returns one item per
// triangle with the moved vertices, saturated to Q16.16, and a degenerate
// flag; a degenerate triangle comes back unchanged.
// The csr_ch channel writes the offset length, signed Q16.16; it is
// always ready and should only be written while no item is in flight.
// An item passes 60 register stages, and a new item can be accepted every
// cycle while the skid register is empty. The stages are the 7 of the cross
// product and length, the 32 stages of the square root, the 18 stages of
// the three dividers that run in parallel and the 3 stages of the offset
// and saturation.
// Reset clears every valid bit and sets the offset length to zero.
// When the receiver stalls, the finished item moves into a one-entry skid
// register and the whole pipeline holds; req_ch.ready stays high until that
// register is occupied, and nothing is dropped or repeated.
module triangle_normal_offset (
   input  logic clock,
   input  logic reset,
   tno_req_if.sink   req_ch,
   tno_rsp_if.source rsp_ch,
   tno_csr_if.sink   csr_ch
);

   tno_pkg::coord_type offset_ff;
   tno_pkg::vert_type in_vert;
   logic en;
   logic front_v, sqrt_v, div_v, pipe_v;
   tno_pkg::front_type front_d;
   tno_pkg::root_type sqrt_d;
   tno_pkg::unit_type div_d;
   tno_pkg::result_type pipe_d, skid_ff, res;
   logic skid_v_ff, skid_v_in;

   assign en = !skid_v_ff;
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      in_vert[0] = req_ch.ax;
      in_vert[1] = req_ch.ay;
      in_vert[2] = req_ch.az;
      in_vert[3] = req_ch.bx;
      in_vert[4] = req_ch.by;
      in_vert[5] = req_ch.bz;
      in_vert[6] = req_ch.cx;
      in_vert[7] = req_ch.cy;
      in_vert[8] = req_ch.cz;
   end

   tno_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_ch.valid), .in_vert(in_vert),
      .out_valid(front_v), .out_data(front_d)
   );

   tno_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(front_v), .in_data(front_d),
      .out_valid(sqrt_v), .out_data(sqrt_d)
   );

   tno_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(sqrt_v), .in_data(sqrt_d),
      .out_valid(div_v), .out_data(div_d)
   );

   tno_move u_move (
      .clock(clock), .reset(reset), .en(en), .offset(offset_ff),
      .in_valid(div_v), .in_data(div_d),
      .out_valid(pipe_v), .out_data(pipe_d)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_ch.valid) begin
         offset_ff <= csr_ch.offset_length;
      end
   end

   always_comb begin
      if (skid_v_ff) begin
         skid_v_in = !rsp_ch.ready;
      end else begin
         skid_v_in = pipe_v && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_ff <= pipe_d;
      end
   end

   assign res = skid_v_ff ? skid_ff : pipe_d;
   assign rsp_ch.valid = skid_v_ff || pipe_v;
   assign rsp_ch.new_ax = res.vert[0];
   assign rsp_ch.new_ay = res.vert[1];
   assign rsp_ch.new_az = res.vert[2];
   assign rsp_ch.new_bx = res.vert[3];
   assign rsp_ch.new_by = res.vert[4];
   assign rsp_ch.new_bz = res.vert[5];
   assign rsp_ch.new_cx = res.vert[6];
   assign rsp_ch.new_cy = res.vert[7];
   assign rsp_ch.new_cz = res.vert[8];
   assign rsp_ch.degenerate = res.degen;

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_ch.ready) |=> !skid_v_ff)
      else $error("skid register did not drain");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (pipe_v && !skid_v_ff && !rsp_ch.ready) |=> skid_v_ff)
      else $error("stalled item not caught by skid register");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_ch.ready) |=> (skid_v_ff && $stable(skid_ff)))
      else $error("skid register lost its item");

endmodule
